### hw/rtl/smes_pkg.sv
// ----------------------------------------------------------------------------
// Sparse matrix entry store package
// Payload types, operation and status codes and sizes shared by the store.
// ----------------------------------------------------------------------------
package smes_pkg;

  localparam int unsigned Capacity  = 256;
  localparam int unsigned IndexBits = 16;
  localparam int unsigned SlotW     = $clog2(Capacity);
  localparam int unsigned CntW      = $clog2(Capacity + 1);
  localparam int unsigned CountW    = 9;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned RegW      = 16;
  localparam int unsigned CfgIdxW   = 8;

  localparam logic [CfgIdxW-1:0] CfgNumRows = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgNumCols = 8'd1;

  localparam logic [RegW-1:0]   NumRowsReset = 16'd16;
  localparam logic [RegW-1:0]   NumColsReset = 16'd16;
  localparam logic [ValueW-1:0] MinusOneBits = 32'hBF80_0000;

  typedef enum logic [1:0] {
    ModeWrite  = 2'd0,
    ModeRead   = 2'd1,
    ModeRemove = 2'd2,
    ModeClear  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusRange    = 2'd1,
    StatusNotFound = 2'd2,
    StatusFull     = 2'd3
  } status_e;

  typedef struct packed {
    mode_e                mode;
    logic [IndexBits-1:0] row_index;
    logic [IndexBits-1:0] col_index;
    logic [ValueW-1:0]    write_value;
  } in_item_t;

  typedef struct packed {
    logic [ValueW-1:0] read_value;
    status_e           status;
    logic [CountW-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic [IndexBits-1:0] row;
    logic [IndexBits-1:0] col;
    logic [ValueW-1:0]    value;
  } entry_t;

endpackage

### hw/rtl/sparse_matrix_entry_store_top.sv
// ----------------------------------------------------------------------------
// Sparse matrix entry store
// Keeps the nonzero entries of one sparse matrix as (row, column, value)
// records in a table with one read port and one write port and per-slot valid bits.
// ----------------------------------------------------------------------------
// One item is worked on at a time. An in-range write or read, and every remove,
// sweep the whole entry table through its one read port, one slot per cycle,
// and the result of such an item is registered on the output after the last
// slot has been compared. Clear and an out-of-range write or read skip the
// sweep and go straight to the finish state. A new item is taken while a result
// still waits on the output; the item then finishes once that result has been
// transferred.
module sparse_matrix_entry_store_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  smes_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output smes_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [smes_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [smes_pkg::RegW-1:0]           cfg_data_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  localparam logic [smes_pkg::SlotW-1:0] LastSlot =
    smes_pkg::SlotW'(smes_pkg::Capacity - 1);

  function automatic logic in_range(logic [smes_pkg::IndexBits-1:0] r,
                                    logic [smes_pkg::IndexBits-1:0] c,
                                    logic [smes_pkg::RegW-1:0]      nr,
                                    logic [smes_pkg::RegW-1:0]      nc);
    in_range = (r != '0) && (smes_pkg::RegW'(r) <= nr) &&
               (c != '0) && (smes_pkg::RegW'(c) <= nc);
  endfunction

  logic [1:0]                       state_q, state_d;
  logic [smes_pkg::RegW-1:0]        num_rows_q, num_cols_q;
  smes_pkg::in_item_t               item_q;
  logic [smes_pkg::SlotW-1:0]       addr_q;
  logic                             issue_q;
  logic                             cmp_vld_q;
  logic [smes_pkg::SlotW-1:0]       cmp_idx_q;
  logic                             cmp_sv_q;
  smes_pkg::entry_t                 mem_rd_q;
  logic                             found_q;
  logic [smes_pkg::SlotW-1:0]       match_q;
  logic [smes_pkg::ValueW-1:0]      match_val_q;
  logic                             free_q;
  logic [smes_pkg::SlotW-1:0]       free_idx_q;
  logic [smes_pkg::Capacity-1:0]    valid_q;
  logic [smes_pkg::CntW-1:0]        stored_count_q, stored_count_d;
  logic                             out_valid_q;
  smes_pkg::out_item_t              out_item_q;

  smes_pkg::entry_t                 mem [smes_pkg::Capacity];

  logic                             in_fire, out_free, fin_fire, cmp_last, hit;
  logic                             item_in_range, in_item_in_range, is_zero;
  smes_pkg::out_item_t              res;
  logic                             mem_we, set_v, clr_v, clr_all;
  logic [smes_pkg::SlotW-1:0]       mem_waddr;
  smes_pkg::entry_t                 mem_wdata;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign fin_fire    = (state_q == StFin) && out_free;
  assign cmp_last    = cmp_vld_q && (cmp_idx_q == LastSlot);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign item_in_range = in_range(item_q.row_index, item_q.col_index,
                                   num_rows_q, num_cols_q);
  assign in_item_in_range = in_range(in_item_i.row_index, in_item_i.col_index,
                                     num_rows_q, num_cols_q);
  assign is_zero = (item_q.write_value[smes_pkg::ValueW-2:0] == '0);
  assign hit = cmp_vld_q && cmp_sv_q && (mem_rd_q.row == item_q.row_index) &&
               (mem_rd_q.col == item_q.col_index);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (in_item_i.mode == smes_pkg::ModeClear ||
              (in_item_i.mode != smes_pkg::ModeRemove && !in_item_in_range)) begin
            state_d = StFin;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (cmp_last) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    res.read_value  = '0;
    res.status      = smes_pkg::StatusOk;
    mem_we          = 1'b0;
    mem_waddr       = match_q;
    mem_wdata.row   = item_q.row_index;
    mem_wdata.col   = item_q.col_index;
    mem_wdata.value = item_q.write_value;
    set_v           = 1'b0;
    clr_v           = 1'b0;
    clr_all         = 1'b0;
    stored_count_d  = stored_count_q;
    case (item_q.mode)
      smes_pkg::ModeWrite: begin
        if (!item_in_range) begin
          res.status = smes_pkg::StatusRange;
        end else if (is_zero) begin
          if (found_q) begin
            clr_v = 1'b1;
            if (stored_count_q != '0) begin
              stored_count_d = stored_count_q - smes_pkg::CntW'(1);
            end
          end
        end else if (found_q) begin
          mem_we = 1'b1;
        end else if (free_q) begin
          mem_we         = 1'b1;
          mem_waddr      = free_idx_q;
          set_v          = 1'b1;
          stored_count_d = stored_count_q + smes_pkg::CntW'(1);
        end else begin
          res.status = smes_pkg::StatusFull;
        end
      end
      smes_pkg::ModeRead: begin
        if (!item_in_range) begin
          res.read_value = smes_pkg::MinusOneBits;
          res.status     = smes_pkg::StatusRange;
        end else if (found_q) begin
          res.read_value = match_val_q;
        end else begin
          res.status = smes_pkg::StatusNotFound;
        end
      end
      smes_pkg::ModeRemove: begin
        if (found_q) begin
          clr_v = 1'b1;
          if (stored_count_q != '0) begin
            stored_count_d = stored_count_q - smes_pkg::CntW'(1);
          end
        end else begin
          res.status = smes_pkg::StatusNotFound;
        end
      end
      smes_pkg::ModeClear: begin
        clr_all        = 1'b1;
        stored_count_d = '0;
      end
      default: begin
      end
    endcase
    res.entry_count = smes_pkg::CountW'(stored_count_d);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && fin_fire) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item_i;
    end
    cmp_idx_q <= addr_q;
    cmp_sv_q  <= valid_q[addr_q];
    if (hit && !found_q) begin
      match_q     <= cmp_idx_q;
      match_val_q <= mem_rd_q.value;
    end
    if (cmp_vld_q && !cmp_sv_q && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
    if (fin_fire) begin
      out_item_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      num_rows_q     <= smes_pkg::NumRowsReset;
      num_cols_q     <= smes_pkg::NumColsReset;
      addr_q         <= '0;
      issue_q        <= 1'b0;
      cmp_vld_q      <= 1'b0;
      found_q        <= 1'b0;
      free_q         <= 1'b0;
      valid_q        <= '0;
      stored_count_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          smes_pkg::CfgNumRows: num_rows_q <= cfg_data_i;
          smes_pkg::CfgNumCols: num_cols_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      cmp_vld_q <= issue_q;
      if (in_fire) begin
        addr_q  <= '0;
        issue_q <= (state_d == StScan);
        found_q <= 1'b0;
        free_q  <= 1'b0;
      end else begin
        if (issue_q) begin
          addr_q <= addr_q + smes_pkg::SlotW'(1);
          if (addr_q == LastSlot) begin
            issue_q <= 1'b0;
          end
        end
        if (hit) begin
          found_q <= 1'b1;
        end
        if (cmp_vld_q && !cmp_sv_q) begin
          free_q <= 1'b1;
        end
        if (fin_fire) begin
          found_q <= 1'b0;
        end
      end
      if (fin_fire) begin
        stored_count_q <= stored_count_d;
        if (clr_all) begin
          valid_q <= '0;
        end else if (set_v) begin
          valid_q[mem_waddr] <= 1'b1;
        end else if (clr_v) begin
          valid_q[match_q] <= 1'b0;
        end
      end
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_count_q <= smes_pkg::CntW'(smes_pkg::Capacity))
    else $error("Entry count exceeds the table capacity.");

  a_count_only_at_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fin_fire |=> $stable(stored_count_q))
    else $error("Entry count changed outside the finish of an operation.");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == smes_pkg::StatusFull |->
      stored_count_q == smes_pkg::CntW'(smes_pkg::Capacity))
    else $error("Table full was reported with free slots left.");

  a_match_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> valid_q[match_q])
    else $error("A matched slot is not marked valid.");
`endif

endmodule
